// ===== hdl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants of the moving average filter: payload structs,
// sequencer states, register indexes and field widths.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int DATA_W            = 16;
  localparam int WIN_W             = 5;
  localparam int WEIGHT_COUNT      = 16;
  localparam int WIDX_W            = 4;
  localparam int SUM_W             = 36;
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 5;

  localparam logic ACT_PUSH   = 1'b0;
  localparam logic ACT_WEIGHT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_MODE   = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] sample;
    logic [WIN_W-1:0]         weight_index;
    logic signed [DATA_W-1:0] weight_value;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic                     divide_error;
  } out_data_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DIVSET,
    S_DIV,
    S_OUT
  } seq_state_t;

endpackage

// ===== hdl/mavg_ram.sv =====
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mavg_div.sv =====
// ----------------------------------------------------------------------------
// mavg_div
// Serial signed divider: one restoring step per cycle on magnitudes, quotient
// truncated toward zero, low bits of the quotient returned.
// ----------------------------------------------------------------------------
module mavg_div
  import mavg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  dividend,
  input  logic signed [DATA_W-1:0] divisor,
  output div_stat_t                stat,
  output logic [DATA_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    dq_r, dq_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   dmag_r, dmag_nxt;
  logic                neg_r, neg_nxt;
  logic [DATA_W:0]     trial;
  logic [DATA_W:0]     diff;

  assign trial = {rem_r, dq_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dmag_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SUM_W - 1);
      dq_nxt   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      dmag_nxt = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
      rem_nxt  = '0;
      neg_nxt  = dividend[SUM_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, dmag_r}) begin
        rem_nxt = diff[DATA_W-1:0];
        dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DATA_W-1:0];
        dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = neg_r ? DATA_W'(-dq_r[DATA_W-1:0]) : dq_r[DATA_W-1:0];

endmodule

// ===== hdl/moving_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter_unit
// Simple or weighted moving average over a ring history of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request of type in_data_t. A push request
//   stores the sample and returns one out_data_t result on out_valid/out_ready;
//   a weight request with index 1 to 16 writes one weight table entry in its
//   accept cycle and returns nothing.
//   cfg_valid/cfg_ready write window_len (index 0) or avg_mode (index 1);
//   cfg_ready is always high.
//   A push runs multiply-accumulate over the history RAM read port for the
//   clamped window length n, picks the divisor, runs the serial divider
//   (36 steps and the done cycle) and loads the output register.
//   A zero divisor skips the divider.
//   in_ready is low while a push is in progress and rises with out_valid, so
//   a new push is taken only once the last result is in the output register.
//   Reset clears history (through a fill count), weights, write position and
//   registers; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   request is accepted meanwhile and its result waits in the sequencer.
// ----------------------------------------------------------------------------
module moving_average_filter_unit
  import mavg_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_data_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int FW      = $clog2(HISTORY_DEPTH + 1);
  localparam int MAX_WIN = (HISTORY_DEPTH < WEIGHT_COUNT) ? HISTORY_DEPTH : WEIGHT_COUNT;
  localparam int CMP_W   = (FW > WIN_W) ? FW : WIN_W;
  localparam int EXT_W   = ((AW > WIN_W) ? AW : WIN_W) + 1;

  seq_state_t               state_r, state_nxt;
  logic [AW-1:0]            wp_r, wp_nxt;
  logic [AW-1:0]            slot_r, slot_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic [WIN_W-1:0]         win_len_r;
  logic                     mode_r;
  logic signed [DATA_W-1:0] weight_r [WEIGHT_COUNT];
  logic [WIN_W-1:0]         n_r, n_nxt;
  logic [WIN_W-1:0]         rk_r, rk_nxt;
  logic [WIN_W-1:0]         ak_r, ak_nxt;
  logic                     av_r, av_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0]        res_r, res_nxt;
  logic                     err_r, err_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_data_t                out_data_r, out_data_nxt;

  logic                       in_fire, out_fire;
  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [DATA_W-1:0]          ram_rdata;
  logic [EXT_W-1:0]           slot_ext, rk_ext;
  logic [WIN_W-1:0]           n_clamp, nm1;
  logic [WIDX_W-1:0]          w_idx;
  logic signed [DATA_W-1:0]   w_sel;
  logic signed [DATA_W-1:0]   smp;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [SUM_W-1:0]    addend;
  logic signed [DATA_W-1:0]   divisor;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic [DATA_W-1:0]          div_q;
  logic                       w_we;
  logic [WIN_W-1:0]           w_wr_m1;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WIN_W'(1);
      mode_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEN: win_len_r <= cfg_data[WIN_W-1:0];
        REG_AVG_MODE:   mode_r    <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    w_we    = in_fire && (in_data.action == ACT_WEIGHT) &&
              (in_data.weight_index inside {[1:WEIGHT_COUNT]});
    w_wr_m1 = in_data.weight_index - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WEIGHT_COUNT; i++) begin
        weight_r[i] <= '0;
      end
    end else if (w_we) begin
      weight_r[w_wr_m1[WIDX_W-1:0]] <= in_data.weight_value;
    end
  end

  mavg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_data.sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    slot_ext = EXT_W'(slot_r);
    rk_ext   = EXT_W'(rk_r);
    if (rk_ext > slot_ext) begin
      ram_raddr = AW'(slot_ext + EXT_W'(HISTORY_DEPTH) - rk_ext);
    end else begin
      ram_raddr = AW'(slot_ext - rk_ext);
    end
    n_clamp = (win_len_r > WIN_W'(MAX_WIN)) ? WIN_W'(MAX_WIN) : win_len_r;
    nm1     = n_r - 1'b1;
    w_idx   = (state_r == S_DIVSET) ? nm1[WIDX_W-1:0] : ak_r[WIDX_W-1:0];
    w_sel   = weight_r[w_idx];
    smp     = (CMP_W'(ak_r) < CMP_W'(fill_r)) ? signed'(ram_rdata) : '0;
    prod    = smp * w_sel;
    addend  = mode_r ? SUM_W'(prod) : SUM_W'(smp);
    if (mode_r) begin
      divisor = (n_r == '0) ? '0 : w_sel;
    end else begin
      divisor = DATA_W'(n_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    rk_nxt        = rk_r;
    ak_nxt        = ak_r;
    av_nxt        = av_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.action == ACT_PUSH)) begin
          ram_we   = 1'b1;
          slot_nxt = wp_r;
          wp_nxt   = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          fill_nxt = (fill_r == FW'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;
          n_nxt    = n_clamp;
          rk_nxt   = '0;
          av_nxt   = 1'b0;
          acc_nxt  = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (rk_r < n_r) begin
          rk_nxt = rk_r + 1'b1;
          ak_nxt = rk_r;
          av_nxt = 1'b1;
        end else begin
          av_nxt = 1'b0;
        end
        if (av_r) begin
          acc_nxt = acc_r + addend;
        end
        if ((rk_r >= n_r) && !av_r) begin
          state_nxt = S_DIVSET;
        end
      end
      S_DIVSET: begin
        if (divisor == '0) begin
          res_nxt   = '0;
          err_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_q;
          err_nxt   = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.average      = res_r;
          out_data_nxt.divide_error = err_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      rk_r        <= '0;
      av_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      rk_r        <= rk_nxt;
      av_r        <= av_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r     <= slot_nxt;
    n_r        <= n_nxt;
    ak_r       <= ak_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  a_push_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.action == ACT_PUSH)) |=> !in_ready)
    else $error("input accepted right after a push");

  a_weight_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.action == ACT_WEIGHT)) |=> $stable(fill_r))
    else $error("weight write changed history fill");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (divisor != '0))
    else $error("divider started with zero divisor");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(HISTORY_DEPTH) >= fill_r)
    else $error("history fill beyond depth");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide state");

endmodule

// ===== dv/mavg_checker.sv =====
// ----------------------------------------------------------------------------
// mavg_checker
// Watches the request, result and register channels of the moving average
// filter, predicts each average from its own copy of the history, weights and
// registers, and compares every result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mavg_checker
  import mavg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_data_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_data_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen,
  output int                    div_errors_seen
);

  localparam int HIST_LEN = HISTORY_DEPTH_DEF;
  localparam int MAX_WIN  = (HIST_LEN < WEIGHT_COUNT) ? HIST_LEN : WEIGHT_COUNT;

  logic signed [DATA_W-1:0] hist_mem [HIST_LEN];
  logic signed [DATA_W-1:0] weights  [WEIGHT_COUNT];
  int unsigned              next_slot;
  logic [WIN_W-1:0]         win_len;
  logic                     weighted;
  out_data_t                pending_averages [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic out_data_t average_of_push(input logic signed [DATA_W-1:0] smp);
    int unsigned slot;
    int unsigned n;
    int unsigned k;
    longint      acc;
    longint      divisor;
    longint      quo;
    out_data_t   res;
    if (next_slot < 1 || next_slot > HIST_LEN)
      next_slot = 1;
    slot = next_slot - 1;
    hist_mem[slot] = smp;
    n = (win_len > MAX_WIN) ? MAX_WIN : win_len;
    acc = 0;
    for (k = 0; k < n; k++) begin
      if (weighted)
        acc += longint'(hist_mem[(slot + HIST_LEN - k) % HIST_LEN]) * longint'(weights[k]);
      else
        acc += longint'(hist_mem[(slot + HIST_LEN - k) % HIST_LEN]);
    end
    if (weighted)
      divisor = (n >= 1) ? longint'(weights[n-1]) : 0;
    else
      divisor = longint'(n);
    if (divisor == 0) begin
      res.average      = '0;
      res.divide_error = 1'b1;
    end else begin
      quo              = acc / divisor;
      res.average      = quo[DATA_W-1:0];
      res.divide_error = 1'b0;
    end
    next_slot = (next_slot % HIST_LEN) + 1;
    return res;
  endfunction

  always @(posedge clk) begin
    out_data_t exp_res;
    if (!rst_n) begin
      foreach (hist_mem[i]) hist_mem[i] = '0;
      foreach (weights[i]) weights[i] = '0;
      next_slot = 1;
      win_len   = WIN_W'(1);
      weighted  = 1'b0;
      pending_averages.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.divide_error)
          div_errors_seen++;
        if (pending_averages.size() == 0) begin
          report_mismatch($sformatf("result avg=%0d err=%0b with no request pending",
                                    out_data.average, out_data.divide_error));
        end else begin
          exp_res = pending_averages.pop_front();
          if (out_data.average !== exp_res.average)
            report_mismatch($sformatf("average %0d, expected %0d",
                                      out_data.average, exp_res.average));
          if (out_data.divide_error !== exp_res.divide_error)
            report_mismatch($sformatf("divide_error %0b, expected %0b",
                                      out_data.divide_error, exp_res.divide_error));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_WEIGHT) begin
          if (in_data.weight_index >= 1 && in_data.weight_index <= WEIGHT_COUNT)
            weights[in_data.weight_index - 1] = in_data.weight_value;
        end else begin
          pending_averages.push_back(average_of_push(in_data.sample));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEN: win_len = cfg_data[WIN_W-1:0];
          REG_AVG_MODE:   weighted = cfg_data[0];
          default: ;
        endcase
      end
      outstanding <= pending_averages.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the moving average filter bench: drives pushes, weight writes and
// register writes with random gaps and output stalls, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mavg_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int ITEM_TARGET   = 1050;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_data_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  out_data_t             out_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int div_errors_seen;
  int cycle_count   = 0;
  int items_done    = 0;
  int pushes_sent   = 0;
  int weights_sent  = 0;
  int reg_writes    = 0;
  int stall_left    = 0;
  bit steady_in     = 1'b0;
  bit steady_out    = 1'b0;

  moving_average_filter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mavg_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .div_errors_seen (div_errors_seen)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return DATA_W'($urandom);
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      default: return DATA_W'(int'($urandom_range(0, 72)) - 8);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady_out && $urandom_range(0, 3) == 0)
        stall_left <= pick_gap();
    end
  end

  task automatic send_req(input in_data_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.action == ACT_PUSH) begin
      pushes_sent++;
      items_done++;
    end else begin
      weights_sent++;
      if (req.weight_index >= 1 && req.weight_index <= WEIGHT_COUNT)
        items_done++;
    end
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push(input logic [DATA_W-1:0] smp);
    in_data_t req;
    req              = '0;
    req.weight_value = DATA_W'($urandom);
    req.action       = ACT_PUSH;
    req.sample       = smp;
    req.weight_index = WIN_W'($urandom);
    send_req(req);
  endtask

  task automatic load_weight(input logic [WIN_W-1:0] idx, input logic [DATA_W-1:0] val);
    in_data_t req;
    req.action       = ACT_WEIGHT;
    req.sample       = DATA_W'($urandom);
    req.weight_index = idx;
    req.weight_value = val;
    send_req(req);
  endtask

  // drain: hold off until every pending average has come back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_mode(input logic weighted);
    logic [CFG_DATA_W-1:0] val;
    val    = CFG_DATA_W'($urandom);
    val[0] = weighted;
    write_reg(REG_AVG_MODE, val);
  endtask

  task automatic random_phase();
    logic [WIN_W-1:0] win;
    logic             weighted;
    int               run_len;
    case ($urandom_range(0, 19))
      0:       win = 5'd0;
      1:       win = WIN_W'($urandom_range(17, 31));
      2:       win = 5'd16;
      3:       win = 5'd1;
      default: win = WIN_W'($urandom_range(1, 16));
    endcase
    weighted = 1'($urandom_range(0, 1));
    write_reg(REG_WINDOW_LEN, win);
    write_mode(weighted);
    steady_in  <= ($urandom_range(0, 4) == 0);
    steady_out <= ($urandom_range(0, 4) == 0);
    if (weighted) begin
      for (int i = 1; i <= WEIGHT_COUNT; i++)
        load_weight(WIN_W'(i), pick_weight());
    end
    run_len = $urandom_range(20, 60);
    repeat (run_len) begin
      if ($urandom_range(0, 11) == 0)
        load_weight(WIN_W'($urandom), pick_weight());
      push(pick_sample());
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push(16'h7FFF);
    push(16'h8000);
    push(16'hFFFF);
    push(16'h0001);
    write_reg(REG_WINDOW_LEN, 5'd16);
    repeat (3) push(16'h7FFF);
    repeat (2) push(16'h8000);
    write_reg(REG_WINDOW_LEN, 5'd0);
    push(16'h0001);
    write_reg(REG_WINDOW_LEN, 5'd31);
    push(16'h0005);
    write_reg(REG_WINDOW_LEN, 5'd1);
    write_mode(1'b1);
    push(16'd100);
    load_weight(5'd1, 16'h8000);
    push(16'h8000);
    load_weight(5'd0, 16'h7FFF);
    load_weight(5'd17, 16'h1234);
    load_weight(5'd31, 16'hFFFF);
    load_weight(5'd16, 16'h7FFF);
    load_weight(5'd2, 16'hFFFF);
    write_reg(REG_WINDOW_LEN, 5'd16);
    push(16'h8000);
    load_weight(5'd16, 16'h0000);
    push(16'h7FFF);

    while (items_done < ITEM_TARGET)
      random_phase();

    drain();
    $display("covered %0d pushes, %0d weight writes, %0d register writes",
             pushes_sent, weights_sent, reg_writes);
    $display("checked %0d averages, %0d of them divide errors, in %0d cycles",
             results_seen, div_errors_seen, cycle_count);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
